### rtl/hrd_pkg.sv
// Package with shared types, codes and helpers of the H4 receive deframer.
`timescale 1ns / 1ps

package hrd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BAD_TYPE = 2'd1;
  localparam logic [1:0] KIND_OVERSIZE = 2'd2;

  // H4 packet type bytes.
  localparam logic [7:0] TYPE_ACL   = 8'h02;
  localparam logic [7:0] TYPE_SCO   = 8'h03;
  localparam logic [7:0] TYPE_EVENT = 8'h04;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT = 1'b1;

  localparam int unsigned MAX_PKT_W     = 17;
  localparam logic [MAX_PKT_W-1:0] MAX_PKT_RESET = 17'd1024;

  // Command queue between the parser and the result sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One command: one to four results that share kind and packet type.
  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      packet_kind;
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            first;
    logic            last;
  } hrd_cmd_t;

  // Header length of a packet type, zero for an unknown type.
  function automatic logic [2:0] header_len(input logic [7:0] t);
    logic [2:0] hl;
    case (t)
      TYPE_ACL:   hl = 3'd4;
      TYPE_SCO:   hl = 3'd3;
      TYPE_EVENT: hl = 3'd2;
      default:    hl = 3'd0;
    endcase
    return hl;
  endfunction

endpackage

### rtl/hrd_if.sv
// Handshake channel interfaces of the H4 receive deframer.
`timescale 1ns / 1ps

interface hrd_rx_if import hrd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hrd_res_if import hrd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] packet_kind;
  logic [7:0] out_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, output kind, output packet_kind, output out_byte,
                  output first_of_packet, output last_of_packet, input ready);
  modport sink (input valid, input kind, input packet_kind, input out_byte,
                input first_of_packet, input last_of_packet, output ready);
endinterface

interface hrd_cfg_if import hrd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MAX_PKT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/hrd_front.sv
// Byte parser: tracks the H4 framing state and turns bytes into result commands.
`timescale 1ns / 1ps

module hrd_front import hrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  hrd_rx_if.sink   rx_i,
  hrd_cfg_if.sink  cfg_i,
  input  logic     q_full_i,
  output logic     push_o,
  output hrd_cmd_t push_cmd_o
);

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic                 enable_q;
  logic [MAX_PKT_W-1:0] max_pkt_q;
  logic [1:0]           phase_q, phase_d;
  logic [7:0]           cur_type_q, cur_type_d;
  logic [2:0]           hdr_cnt_q, hdr_cnt_d;
  logic [15:0]          left_q, left_d;
  logic [3:0][7:0]      hdr_q;
  logic [3:0][7:0]      hdr_view;
  logic                 take;
  logic [2:0]           hl;
  logic [2:0]           cnt_inc;
  logic [15:0]          len;
  logic [15:0]          left_dec;
  logic                 oversize;

  // A request is accepted whenever the command queue has room; it is only processed while enabled.
  assign rx_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign take        = rx_i.valid && rx_i.ready && enable_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      max_pkt_q <= MAX_PKT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENABLE:  enable_q  <= cfg_i.data[0];
        CFG_MAX_PKT: max_pkt_q <= cfg_i.data;
        default:     ;
      endcase
    end
  end

  // Header view with the current byte merged in at its slot.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hdr_view[i] = (hdr_cnt_q[1:0] == 2'(i)) ? rx_i.rx_byte : hdr_q[i];
    end
  end

  assign hl       = header_len(cur_type_q);
  assign cnt_inc  = hdr_cnt_q + 3'd1;
  assign left_dec = left_q - 16'd1;

  always_comb begin
    case (cur_type_q)
      TYPE_ACL: len = {hdr_view[3], hdr_view[2]};
      TYPE_SCO: len = {8'd0, hdr_view[2]};
      default:  len = {8'd0, hdr_view[1]};
    endcase
  end

  assign oversize = (cur_type_q == TYPE_ACL) &&
                    (({1'b0, len} + 17'd4) > max_pkt_q);

  // Framing state machine.
  always_comb begin
    phase_d    = phase_q;
    cur_type_d = cur_type_q;
    hdr_cnt_d  = hdr_cnt_q;
    left_d     = left_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    push_cmd_o.packet_kind = cur_type_q;
    push_cmd_o.data[0]     = rx_i.rx_byte;
    if (take) begin
      case (phase_q)
        PH_HEADER: begin
          hdr_cnt_d = cnt_inc;
          if (hl == 3'd0 || cnt_inc >= hl) begin
            if (oversize) begin
              push_o          = 1'b1;
              push_cmd_o.kind = KIND_OVERSIZE;
              phase_d         = PH_TYPE;
              hdr_cnt_d       = 3'd0;
              left_d          = 16'd0;
            end else begin
              push_o              = (hl != 3'd0);
              push_cmd_o.kind     = KIND_BYTE;
              push_cmd_o.data     = hdr_view;
              push_cmd_o.last_idx = 2'(hl - 3'd1);
              push_cmd_o.first    = 1'b1;
              push_cmd_o.last     = (len == 16'd0);
              hdr_cnt_d           = 3'd0;
              left_d              = len;
              phase_d             = (len == 16'd0) ? PH_TYPE : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          left_d          = left_dec;
          push_o          = 1'b1;
          push_cmd_o.kind = KIND_BYTE;
          push_cmd_o.last = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          // Expect a type byte; the spare phase code behaves the same.
          if (rx_i.rx_byte inside {TYPE_ACL, TYPE_SCO, TYPE_EVENT}) begin
            cur_type_d = rx_i.rx_byte;
            hdr_cnt_d  = 3'd0;
            left_d     = 16'd0;
            phase_d    = PH_HEADER;
          end else begin
            phase_d                = PH_TYPE;
            push_o                 = 1'b1;
            push_cmd_o.kind        = KIND_BAD_TYPE;
            push_cmd_o.packet_kind = 8'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      cur_type_q <= 8'd0;
      hdr_cnt_q  <= 3'd0;
      left_q     <= 16'd0;
    end else begin
      phase_q    <= phase_d;
      cur_type_q <= cur_type_d;
      hdr_cnt_q  <= hdr_cnt_d;
      left_q     <= left_d;
    end
  end

  // Header byte store, written only while a header is collected.
  always_ff @(posedge clk_i) begin
    if (take && phase_q == PH_HEADER) begin
      hdr_q[hdr_cnt_q[1:0]] <= rx_i.rx_byte;
    end
  end

endmodule

### rtl/hrd_cmd_queue.sv
// Short command queue between the byte parser and the result sequencer.
`timescale 1ns / 1ps

module hrd_cmd_queue import hrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hrd_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output hrd_cmd_t pop_cmd_o
);

  hrd_cmd_t                   slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]     cnt_q;
  logic                       do_push, do_pop;

  assign full_o    = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QUEUE_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QUEUE_CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/hrd_back.sv
// Result sequencer: expands each command into results behind an output register.
`timescale 1ns / 1ps

module hrd_back import hrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  hrd_cmd_t q_cmd_i,
  output logic     pop_o,
  hrd_res_if.source res_o
);

  logic       busy_q;
  hrd_cmd_t   cmd_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] pkind_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;
  logic       adv;
  logic       last_elem;

  // Move one result of the held command into the output register whenever it is free or drained.
  assign adv       = busy_q && (!out_valid_q || res_o.ready);
  assign last_elem = (idx_q == cmd_q.last_idx);
  assign pop_o     = q_valid_i && (!busy_q || (adv && last_elem));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (adv) begin
        busy_q <= !last_elem;
        idx_q  <= idx_q + 2'd1;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (adv) begin
      kind_q  <= cmd_q.kind;
      pkind_q <= cmd_q.packet_kind;
      byte_q  <= cmd_q.data[idx_q];
      first_q <= cmd_q.first && (idx_q == 2'd0);
      last_q  <= cmd_q.last && last_elem;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = kind_q;
  assign res_o.packet_kind     = pkind_q;
  assign res_o.out_byte        = byte_q;
  assign res_o.first_of_packet = first_q;
  assign res_o.last_of_packet  = last_q;

endmodule

### rtl/hci_h4_rx_deframer_core.sv
// Top level of the H4 receive deframer.
//
// Bytes from the UART receiver enter on the rx_i channel, one request per cycle
// while rx_i.ready is high. Results leave on res_o: packet bytes with first and
// last marks, or one error result for an unknown type byte or an oversize ACL.
// The cfg_i channel writes the enable bit (index 0) and the ACL size limit
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block does not enforce this. A complete header yields two to
// four results from the one byte that ends it, or one oversize result; every
// other byte yields at most one. An accepted byte reaches its first result
// through the command queue, sequencer command register and output register.
// Input runs at one byte per cycle as long as the four-entry command queue has
// room; the sequencer drains one result per cycle while the receiver is ready,
// so only header bursts can fill the queue. When the receiver stalls, the output
// register holds its result, the queue fills, and rx_i.ready drops once full.
// Reset clears the framing state, disables the block and sets the limit to
// 1024 bytes; no clearing pass is needed.
`timescale 1ns / 1ps

module hci_h4_rx_deframer_core import hrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrd_rx_if.sink     rx_i,
  hrd_cfg_if.sink    cfg_i,
  hrd_res_if.source  res_o
);

  logic     push;
  hrd_cmd_t push_cmd;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  hrd_cmd_t q_cmd;

  // Byte parser.
  hrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .cfg_i      (cfg_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Command queue.
  hrd_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // Result sequencer.
  hrd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule
